FILE: rtl/dual_stack_with_trash_defines.svh
// Assertion macros for the checker of this block.
`ifndef DUAL_STACK_WITH_TRASH_DEFINES_SVH
`define DUAL_STACK_WITH_TRASH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define DSWT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DSWT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dswt_pkg.sv
`default_nettype none

package dswt_pkg;

    localparam int MAIN_DEPTH  = 256;
    localparam int TRASH_DEPTH = 256;

    localparam int MAIN_AW  = $clog2(MAIN_DEPTH);
    localparam int TRASH_AW = $clog2(TRASH_DEPTH);
    localparam int MAIN_CW  = $clog2(MAIN_DEPTH + 1);
    localparam int TRASH_CW = $clog2(TRASH_DEPTH + 1);

    localparam int DATA_W  = 64;
    localparam int DEPTH_W = 9;

    // command codes
    localparam logic [2:0] CMD_PUSH    = 3'd0;
    localparam logic [2:0] CMD_POP     = 3'd1;
    localparam logic [2:0] CMD_TRASH   = 3'd2;
    localparam logic [2:0] CMD_RESTORE = 3'd3;
    localparam logic [2:0] CMD_QUERY   = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]        command;
        logic [DATA_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [DATA_W-1:0]  moved_value;
        logic [DEPTH_W-1:0] main_depth;
        logic [DEPTH_W-1:0] trash_depth;
        logic               main_empty;
    } rsp_t;

    typedef struct packed {
        logic               we;
        logic [MAIN_AW-1:0] waddr;
        logic [DATA_W-1:0]  wdata;
        logic [MAIN_AW-1:0] raddr;
    } main_mreq_t;

    typedef struct packed {
        logic                we;
        logic [TRASH_AW-1:0] waddr;
        logic [DATA_W-1:0]   wdata;
        logic [TRASH_AW-1:0] raddr;
    } trash_mreq_t;

endpackage

`default_nettype wire

FILE: rtl/dswt_ram.sv
`default_nettype none

module dswt_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/dswt_ctrl.sv
`default_nettype none

module dswt_ctrl
    import dswt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire req_t  request,
    output logic       done,
    output rsp_t       result,
    output main_mreq_t main_req,
    input  wire logic [DATA_W-1:0] main_rdata,
    output trash_mreq_t trash_req,
    input  wire logic [DATA_W-1:0] trash_rdata
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [MAIN_CW-1:0]  main_count_reg, main_count_next;
    logic [TRASH_CW-1:0] trash_count_reg, trash_count_next;
    req_t                req_reg;
    rsp_t                result_reg, result_next;
    logic                done_reg, done_next;

    logic main_is_empty, main_is_full, trash_is_empty, trash_is_full;
    logic accept;
    logic [1:0]        status;
    logic [DATA_W-1:0] moved;

    assign accept         = start && (state_reg == S_IDLE);
    assign main_is_empty  = (main_count_reg == '0);
    assign trash_is_empty = (trash_count_reg == '0);
    assign main_is_full   = (main_count_reg == MAIN_CW'(MAIN_DEPTH));
    assign trash_is_full  = (trash_count_reg == TRASH_CW'(TRASH_DEPTH));

    always_comb
    begin
        // tops are read every cycle; counts only move in S_EXEC
        main_req.raddr   = MAIN_AW'(main_count_reg - MAIN_CW'(1));
        trash_req.raddr  = TRASH_AW'(trash_count_reg - TRASH_CW'(1));
        main_req.waddr   = MAIN_AW'(main_count_reg);
        trash_req.waddr  = TRASH_AW'(trash_count_reg);
        state_next       = state_reg;
        main_count_next  = main_count_reg;
        trash_count_next = trash_count_reg;
        status           = STAT_OK;
        moved            = '0;
        main_req.we      = 1'b0;
        main_req.wdata   = req_reg.push_value;
        trash_req.we     = 1'b0;
        trash_req.wdata  = main_rdata;
        done_next        = 1'b0;
        result_next      = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (req_reg.command)
                    CMD_PUSH:
                    begin
                        if (main_is_full)
                        begin
                            status = STAT_FULL;
                        end
                        else
                        begin
                            main_req.we     = 1'b1;
                            main_count_next = main_count_reg + MAIN_CW'(1);
                            moved           = req_reg.push_value;
                        end
                    end
                    CMD_POP:
                    begin
                        if (main_is_empty)
                        begin
                            status = STAT_EMPTY;
                        end
                        else
                        begin
                            main_count_next = main_count_reg - MAIN_CW'(1);
                            moved           = main_rdata;
                        end
                    end
                    CMD_TRASH:
                    begin
                        if (main_is_empty)
                        begin
                            status = STAT_EMPTY;
                        end
                        else if (trash_is_full)
                        begin
                            status = STAT_FULL;
                        end
                        else
                        begin
                            trash_req.we     = 1'b1;
                            main_count_next  = main_count_reg - MAIN_CW'(1);
                            trash_count_next = trash_count_reg + TRASH_CW'(1);
                            moved            = main_rdata;
                        end
                    end
                    CMD_RESTORE:
                    begin
                        if (trash_is_empty)
                        begin
                            status = STAT_EMPTY;
                        end
                        else if (main_is_full)
                        begin
                            status = STAT_FULL;
                        end
                        else
                        begin
                            main_req.we      = 1'b1;
                            main_req.wdata   = trash_rdata;
                            trash_count_next = trash_count_reg - TRASH_CW'(1);
                            main_count_next  = main_count_reg + MAIN_CW'(1);
                            moved            = trash_rdata;
                        end
                    end
                    default:
                    begin
                        // query and unused codes: no change
                    end
                endcase
                result_next.status      = status;
                result_next.moved_value = moved;
                result_next.main_depth  = DEPTH_W'(main_count_next);
                result_next.trash_depth = DEPTH_W'(trash_count_next);
                result_next.main_empty  = (main_count_next == '0);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            main_count_reg  <= '0;
            trash_count_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            main_count_reg  <= main_count_next;
            trash_count_reg <= trash_count_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        result_reg <= result_next;
    end

    assign busy   = (state_reg == S_EXEC);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/dual_stack_with_trash.sv
// A beat accepted in S_IDLE executes in S_EXEC, which registers done and the result.
// No new command is taken while one executes (busy covers S_EXEC), since the stack
// tops must be read from the synchronous RAMs before the update can be written back.
// Reset (rst_n low, async): both counts go to zero and no result is pending;
// the RAM contents are not cleared. The receiver cannot stall the result.
`default_nettype none

module dual_stack_with_trash
    import dswt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t request,
    output logic      done,
    output rsp_t      result
);

    // Memory request groups from the controller to each stack RAM.
    main_mreq_t        main_req;
    trash_mreq_t       trash_req;
    logic [DATA_W-1:0] main_rdata;
    logic [DATA_W-1:0] trash_rdata;

    // Controller: accepts a beat when idle, reads both tops in the accept
    // cycle, then in the execute cycle checks empty/full, writes the new
    // top back and updates the counts. busy covers the execute cycle, so
    // a read never overlaps a write of the same entry; no forwarding needed.
    dswt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .main_req    (main_req),
        .main_rdata  (main_rdata),
        .trash_req   (trash_req),
        .trash_rdata (trash_rdata)
    );

    // Main stack storage: entry k holds element k from the bottom.
    dswt_ram #(
        .DEPTH (MAIN_DEPTH),
        .WIDTH (DATA_W)
    ) u_main_ram (
        .clk   (clk),
        .we    (main_req.we),
        .waddr (main_req.waddr),
        .wdata (main_req.wdata),
        .raddr (main_req.raddr),
        .rdata (main_rdata)
    );

    // Trash stack storage, same layout.
    dswt_ram #(
        .DEPTH (TRASH_DEPTH),
        .WIDTH (DATA_W)
    ) u_trash_ram (
        .clk   (clk),
        .we    (trash_req.we),
        .waddr (trash_req.waddr),
        .wdata (trash_req.wdata),
        .raddr (trash_req.raddr),
        .rdata (trash_rdata)
    );

endmodule

`default_nettype wire

FILE: rtl/dswt_chk.sv
`default_nettype none
`include "dual_stack_with_trash_defines.svh"

module dswt_chk
    import dswt_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire req_t request,
    input wire logic done,
    input wire rsp_t result
);

    `DSWT_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "no busy after accepted beat")
    `DSWT_ASSERT_NOW(a_done_has_cmd, done, $past(start && !busy, 2), "result without command")
    `DSWT_ASSERT_NOW(a_err_zero_val, done && (result.status != STAT_OK), result.moved_value == '0, "error result carries a value")
    `DSWT_ASSERT_NOW(a_empty_depth, done && result.main_empty, result.main_depth == '0, "main_empty with nonzero depth")

endmodule

bind dual_stack_with_trash dswt_chk u_chk (.*);

`default_nettype wire

FILE: tb/sv/tb_dual_stack_with_trash.sv
`default_nettype none

module tb_dual_stack_with_trash;

    timeunit 1ns;
    timeprecision 1ps;

    import dswt_pkg::*;

    // Burst end conditions for the random part.
    typedef enum int {
        UNTIL_MAIN_FULL,
        UNTIL_TRASH_FULL,
        UNTIL_MAIN_EMPTY,
        FIXED_LEN
    } burst_goal_t;

    // Shadow of both stacks. Each accepted command beat is applied to the
    // shadow right away, and the response it must produce is queued.
    class stack_scoreboard_t;
        logic [DATA_W-1:0] main_mem[MAIN_DEPTH];
        logic [DATA_W-1:0] trash_mem[TRASH_DEPTH];
        int unsigned       main_cnt;
        int unsigned       trash_cnt;
        rsp_t              rsp_q[$];
        int                errors;

        function new();
            main_cnt  = 0;
            trash_cnt = 0;
            errors    = 0;
        endfunction

        function int pending();
            return rsp_q.size();
        endfunction

        // Apply one accepted command to the shadow stacks.
        function void note_request(req_t r);
            rsp_t              rsp;
            logic [DATA_W-1:0] v;
            rsp        = '0;
            rsp.status = STAT_OK;
            v          = '0;
            case (r.command)
                CMD_PUSH:
                    if (main_cnt >= MAIN_DEPTH)
                        rsp.status = STAT_FULL;
                    else
                    begin
                        main_mem[main_cnt] = r.push_value;
                        main_cnt++;
                        v = r.push_value;
                    end
                CMD_POP:
                    if (main_cnt == 0)
                        rsp.status = STAT_EMPTY;
                    else
                    begin
                        main_cnt--;
                        v = main_mem[main_cnt];
                    end
                // source check comes before the destination check
                CMD_TRASH:
                    if (main_cnt == 0)
                        rsp.status = STAT_EMPTY;
                    else if (trash_cnt >= TRASH_DEPTH)
                        rsp.status = STAT_FULL;
                    else
                    begin
                        main_cnt--;
                        v = main_mem[main_cnt];
                        trash_mem[trash_cnt] = v;
                        trash_cnt++;
                    end
                CMD_RESTORE:
                    if (trash_cnt == 0)
                        rsp.status = STAT_EMPTY;
                    else if (main_cnt >= MAIN_DEPTH)
                        rsp.status = STAT_FULL;
                    else
                    begin
                        trash_cnt--;
                        v = trash_mem[trash_cnt];
                        main_mem[main_cnt] = v;
                        main_cnt++;
                    end
                // query and unused codes change nothing
                default: ;
            endcase
            rsp.moved_value = v;
            rsp.main_depth  = DEPTH_W'(main_cnt);
            rsp.trash_depth = DEPTH_W'(trash_cnt);
            rsp.main_empty  = (main_cnt == 0);
            rsp_q = {rsp_q, rsp};
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (rsp_q.size() == 0)
            begin
                $error("response beat with no command outstanding: %p", got);
                errors++;
                return;
            end
            want = rsp_q.pop_front();
            compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
            compare_field("moved_value", want.moved_value, got.moved_value);
            compare_field("main_depth", DATA_W'(want.main_depth), DATA_W'(got.main_depth));
            compare_field("trash_depth", DATA_W'(want.trash_depth),
                          DATA_W'(got.trash_depth));
            compare_field("main_empty", DATA_W'(want.main_empty), DATA_W'(got.main_empty));
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    stack_scoreboard_t sb = new();

    int items_sent = 0;

    always #4 clk = ~clk;

    dual_stack_with_trash DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // Monitor: everything is sampled just after the rising edge, so the
    // values seen are the ones the DUT saw at that edge. Responses are
    // checked before the new command is noted; a response can never belong
    // to a command accepted at the same edge (done is registered from S_EXEC).
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_request(request);
        end
    end

    // Sender idle percentage, cycling through phases every 60 beats:
    // none, 46, none (receiver stall phase: the result strobe cannot be
    // held off, so nothing to do there), 21.
    function automatic int idle_pct();
        case ((items_sent / 60) % 4)
            1:       return 46;
            3:       return 21;
            default: return 0;
        endcase
    endfunction

    // Present one command beat and hold it until the DUT takes it.
    // start stays high on return; the caller lowers it only for a gap.
    task automatic issue(logic [2:0] cmd, logic [DATA_W-1:0] value);
        req_t r;
        r.command    = cmd;
        r.push_value = value;
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    // One beat plus a possible idle gap with start low.
    task automatic send_cmd(logic [2:0] cmd, logic [DATA_W-1:0] value);
        int gap;
        issue(cmd, value);
        gap = 0;
        if ($urandom_range(99) < idle_pct())
            gap = $urandom_range(3, 1);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Values lean on the extremes and walking ones now and then.
    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'(1) << $urandom_range(DATA_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic bit goal_met(burst_goal_t goal);
        case (goal)
            UNTIL_MAIN_FULL:  return sb.main_cnt >= MAIN_DEPTH;
            UNTIL_TRASH_FULL: return sb.trash_cnt >= TRASH_DEPTH;
            UNTIL_MAIN_EMPTY: return sb.main_cnt == 0;
            default:          return 1'b0;
        endcase
    endfunction

    // The favored command pct percent of the time, else any code 0..7 (noise).
    // Runs until the goal holds or max_items, then 'extra' more beats
    // to hit the full/empty corners.
    task automatic run_burst(logic [2:0] favored, int pct, burst_goal_t goal,
                             int max_items, int extra);
        logic [2:0] cmd;
        int         n;
        n = 0;
        while (n < max_items + extra)
        begin
            if (n >= max_items || goal_met(goal))
            begin
                if (extra == 0)
                    break;
                extra--;
            end
            else
                n++;
            cmd = ($urandom_range(99) < pct) ? favored : 3'($urandom_range(7));
            send_cmd(cmd, rand_value());
        end
    endtask

    initial
    begin
        logic [2:0] fav;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // every source empty on a fresh stack
        send_cmd(CMD_QUERY, '1);
        send_cmd(CMD_POP, '0);
        send_cmd(CMD_TRASH, '1);
        send_cmd(CMD_RESTORE, 64'h0123_4567_89ab_cdef);
        // value extremes
        send_cmd(CMD_PUSH, '0);
        send_cmd(CMD_PUSH, '1);
        send_cmd(CMD_PUSH, 64'h8000_0000_0000_0000);
        send_cmd(CMD_PUSH, 64'h5555_5555_5555_5555);
        send_cmd(CMD_PUSH, 64'haaaa_aaaa_aaaa_aaaa);
        send_cmd(CMD_QUERY, 64'hdead_beef_0000_0001);
        send_cmd(CMD_POP, '1);
        send_cmd(CMD_TRASH, '0);
        send_cmd(CMD_TRASH, '1);
        send_cmd(CMD_RESTORE, '0);
        send_cmd(CMD_POP, '0);
        send_cmd(CMD_RESTORE, '1);
        // unused codes behave as query
        send_cmd(3'd5, '1);
        send_cmd(3'd6, '0);
        send_cmd(3'd7, 64'hffff_0000_ffff_0000);
        // drain both, restore into empty main, then restore from empty trash
        send_cmd(CMD_TRASH, '0);
        send_cmd(CMD_POP, '0);
        send_cmd(CMD_POP, '0);
        send_cmd(CMD_RESTORE, '0);
        send_cmd(CMD_RESTORE, '0);

        // --- random, structured ---
        // fill main past full: push into full main
        run_burst(CMD_PUSH, 92, UNTIL_MAIN_FULL, 600, 12);
        // move everything to trash; trash full then source empty with
        // destination full
        run_burst(CMD_TRASH, 92, UNTIL_TRASH_FULL, 600, 12);
        run_burst(CMD_TRASH, 92, UNTIL_MAIN_EMPTY, 100, 6);
        // refill main with trash still full: moves into full trash
        run_burst(CMD_PUSH, 90, UNTIL_MAIN_FULL, 600, 4);
        run_burst(CMD_TRASH, 85, FIXED_LEN, 12, 0);
        run_burst(CMD_PUSH, 90, UNTIL_MAIN_FULL, 100, 2);
        // restore into full main
        run_burst(CMD_RESTORE, 85, FIXED_LEN, 15, 0);
        run_burst(CMD_POP, 80, FIXED_LEN, 40, 0);

        // --- random, mixed bursts ---
        while (items_sent < 1030)
        begin
            fav = 3'($urandom_range(4));
            run_burst(fav, $urandom_range(70, 40), FIXED_LEN, $urandom_range(50, 10), 0);
        end

        start <= 1'b0;

        // drain: wait for every pending response, then keep clocking to catch stray strobes
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (sb.errors == 0)
            $display("tb_dual_stack_with_trash passed");
        else
            $display("tb_dual_stack_with_trash failed");
        $finish;
    end

    // Watchdog: ends a run that hangs, reporting it as failed.
    initial
    begin
        #2_000_000;
        $display("tb_dual_stack_with_trash failed");
        $finish;
    end

endmodule

`default_nettype wire
